### rtl/tksk_pkg.sv
package tksk_pkg;

  // Field widths of the item channels.
  localparam int OP_W      = 1;
  localparam int SCORE_W   = 24;
  localparam int TAG_W     = 32;
  localparam int PLAYERS_W = 4;
  localparam int RIDX_W    = 6;
  localparam int SLOT_W    = 6;
  localparam int K_W       = 7;

  // Internal slot index width, wide enough for the largest table of 256 slots.
  localparam int IDX_W = 8;

  // Default table size and register reset value.
  localparam int SLOTS_DEF = 64;
  localparam logic [K_W-1:0] K_ACTIVE_RST = K_W'(10);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_OFFER = 1'b0;
  localparam logic [OP_W-1:0] OP_READ  = 1'b1;

  // Scan record handed from cell to cell.
  typedef struct packed {
    logic                 valid;
    logic                 is_read;
    logic [IDX_W-1:0]     ridx;
    logic                 found_free;
    logic [IDX_W-1:0]     free_idx;
    logic                 have_worst;
    logic [IDX_W-1:0]     worst_idx;
    logic [SCORE_W-1:0]   worst_score;
    logic                 rd_used;
    logic [SCORE_W-1:0]   rd_score;
    logic [TAG_W-1:0]     rd_tag;
    logic [PLAYERS_W-1:0] rd_players;
  } rec_t;

  // Write broadcast to all cells.
  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     idx;
    logic [SCORE_W-1:0]   score;
    logic [TAG_W-1:0]     tag;
    logic [PLAYERS_W-1:0] players;
  } wr_t;

endpackage

### rtl/tksk_req_if.sv
interface tksk_req_if import tksk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [SCORE_W-1:0]   cand_score;
  logic [TAG_W-1:0]     cand_tag;
  logic [PLAYERS_W-1:0] cand_players;
  logic [RIDX_W-1:0]    read_index;

  modport source (output valid, opcode, cand_score, cand_tag, cand_players, read_index,
                  input ready);
  modport sink (input valid, opcode, cand_score, cand_tag, cand_players, read_index,
                output ready);
endinterface

### rtl/tksk_rsp_if.sv
interface tksk_rsp_if import tksk_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic                 evicted;
  logic [SLOT_W-1:0]    slot;
  logic                 slot_used;
  logic [SCORE_W-1:0]   slot_score;
  logic [TAG_W-1:0]     slot_tag;
  logic [PLAYERS_W-1:0] slot_players;

  modport source (output valid, accepted, evicted, slot, slot_used, slot_score, slot_tag,
                  slot_players, input ready);
  modport sink (input valid, accepted, evicted, slot, slot_used, slot_score, slot_tag,
                slot_players, output ready);
endinterface

### rtl/tksk_cell.sv
module tksk_cell import tksk_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [K_W-1:0] k_active,
  input  wr_t            wr,
  input  rec_t           rec_in,
  output rec_t           rec_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                 used;
  logic [SCORE_W-1:0]   score;
  logic [TAG_W-1:0]     tag;
  logic [PLAYERS_W-1:0] players;
  logic                 active;
  logic                 wr_hit;
  rec_t                 rec_next;

  // The slot takes part in offers only when it lies below k_active.
  assign active = MY_IDX < IDX_W'(k_active);
  assign wr_hit = wr.en && (wr.idx == MY_IDX);

  // Fold this slot into the passing record.
  always_comb begin
    rec_next = rec_in;
    if (rec_in.valid) begin
      if (rec_in.is_read) begin
        if (rec_in.ridx == MY_IDX) begin
          rec_next.rd_used    = used;
          rec_next.rd_score   = score;
          rec_next.rd_tag     = tag;
          rec_next.rd_players = players;
        end
      end else if (active) begin
        if (used) begin
          if (!rec_in.have_worst || (score < rec_in.worst_score)) begin
            rec_next.have_worst  = 1'b1;
            rec_next.worst_idx   = MY_IDX;
            rec_next.worst_score = score;
          end
        end else if (!rec_in.found_free) begin
          rec_next.found_free = 1'b1;
          rec_next.free_idx   = MY_IDX;
        end
      end
    end
  end

  // Record register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_out.valid <= 1'b0;
    end else begin
      rec_out <= rec_next;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr_hit) begin
      used <= 1'b1;
    end
  end

  // Stored candidate.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      score   <= wr.score;
      tag     <= wr.tag;
      players <= wr.players;
    end
  end

endmodule

### rtl/tksk_ctrl.sv
module tksk_ctrl import tksk_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata,
  output logic [K_W-1:0] k_active,
  tksk_req_if.sink       req,
  tksk_rsp_if.source     rsp,
  output rec_t           launch,
  input  rec_t           chain_out,
  output wr_t            wr
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t               state;
  logic [SCORE_W-1:0]   cand_score;
  logic [TAG_W-1:0]     cand_tag;
  logic [PLAYERS_W-1:0] cand_players;
  logic                 res_accepted;
  logic                 res_evicted;
  logic [SLOT_W-1:0]    res_slot;
  logic                 res_used;
  logic [SCORE_W-1:0]   res_score;
  logic [TAG_W-1:0]     res_tag;
  logic [PLAYERS_W-1:0] res_players;
  logic                 take_in;
  logic                 out_free;
  logic                 do_write;
  logic                 do_evict;
  logic [IDX_W-1:0]     target;

  assign req.ready = (state == ST_IDLE);
  assign take_in   = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // Decision taken when the record leaves the last cell.
  always_comb begin
    do_write = 1'b0;
    do_evict = 1'b0;
    target   = chain_out.free_idx;
    if (!chain_out.is_read) begin
      if (chain_out.found_free) begin
        do_write = 1'b1;
      end else if (chain_out.have_worst && (cand_score > chain_out.worst_score)) begin
        do_write = 1'b1;
        do_evict = 1'b1;
        target   = chain_out.worst_idx;
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      k_active <= K_ACTIVE_RST;
    end else if (cfg_we) begin
      k_active <= cfg_wdata;
    end
  end

  // Sequencer with its registered controls, the empty record that starts the scan
  // and the write broadcast.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launch.valid <= 1'b0;
      wr.en        <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      launch.valid <= 1'b0;
      wr.en        <= 1'b0;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take_in) begin
            launch.valid       <= 1'b1;
            launch.is_read     <= (req.opcode == OP_READ);
            launch.ridx        <= IDX_W'(req.read_index);
            launch.found_free  <= 1'b0;
            launch.free_idx    <= '0;
            launch.have_worst  <= 1'b0;
            launch.worst_idx   <= '0;
            launch.worst_score <= '0;
            launch.rd_used     <= 1'b0;
            launch.rd_score    <= '0;
            launch.rd_tag      <= '0;
            launch.rd_players  <= '0;
            state              <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain_out.valid) begin
            wr.en      <= do_write;
            wr.idx     <= target;
            wr.score   <= cand_score;
            wr.tag     <= cand_tag;
            wr.players <= cand_players;
            state      <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Candidate capture.
  always_ff @(posedge clk) begin
    if (take_in) begin
      cand_score   <= req.cand_score;
      cand_tag     <= req.cand_tag;
      cand_players <= req.cand_players;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && chain_out.valid) begin
      res_accepted <= do_write;
      res_evicted  <= do_evict;
      if (chain_out.is_read) begin
        res_slot <= chain_out.ridx[SLOT_W-1:0];
      end else if (do_write) begin
        res_slot <= target[SLOT_W-1:0];
      end else begin
        res_slot <= '0;
      end
      res_used    <= chain_out.rd_used;
      res_score   <= chain_out.rd_score;
      res_tag     <= chain_out.rd_tag;
      res_players <= chain_out.rd_players;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if ((state == ST_HOLD) && out_free) begin
      rsp.accepted     <= res_accepted;
      rsp.evicted      <= res_evicted;
      rsp.slot         <= res_slot;
      rsp.slot_used    <= res_used;
      rsp.slot_score   <= res_score;
      rsp.slot_tag     <= res_tag;
      rsp.slot_players <= res_players;
    end
  end

  // A record only comes out of the chain while a scan is pending.
  a_chain_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (state == ST_SCAN))
    else $error("scan record left the chain outside a scan");

  // A table write follows the end of a scan.
  a_write_after_scan: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ($past(state) == ST_SCAN) && (state == ST_HOLD))
    else $error("table write without a finished scan");

  // Free slots found by the scan of an offer lie inside the table.
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (chain_out.valid && !chain_out.is_read && chain_out.found_free)
      |-> ({1'b0, chain_out.free_idx} < (IDX_W+1)'(SLOTS)))
    else $error("free slot beyond the table");

  // An eviction is always an accepted offer.
  a_evict_accepted: assert property (@(posedge clk) disable iff (rst)
    (wr.en && res_evicted) |-> res_accepted)
    else $error("eviction reported without acceptance");

endmodule

### rtl/top_k_score_keeper_top.sv
// Channel  Modport  Carries
// -------  -------  ----------------------------------------------------------
// req      sink     opcode, cand_score, cand_tag, cand_players, read_index
// rsp      source   accepted, evicted, slot, slot_used, slot_score, slot_tag,
//                   slot_players
// cfg      write    cfg_we, cfg_wdata (k_active)
//
// Every item, offer or read, passes after acceptance through the launch register,
// one register per slot cell, the decision and table write, and the output
// register.
// A new item is accepted in the cycle after its predecessor's result is loaded,
// so the block takes no new item before it is through with the last one.
// Reset is synchronous and clears all occupancy flags at once.
// A stalled result holds in the output register; the block then waits in its
// final step until the register frees.
module top_k_score_keeper_top import tksk_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata,
  tksk_req_if.sink       req,
  tksk_rsp_if.source     rsp
);

  logic [K_W-1:0] k_active;
  wr_t            wr;
  rec_t           chain [SLOTS+1];

  // Sequencer, register and result path.
  tksk_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .k_active (k_active),
    .req      (req),
    .rsp      (rsp),
    .launch   (chain[0]),
    .chain_out(chain[SLOTS]),
    .wr       (wr)
  );

  // Row of slot cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tksk_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .k_active(k_active),
      .wr      (wr),
      .rec_in  (chain[i]),
      .rec_out (chain[i+1])
    );
  end

endmodule

### tb/score_keeper_checker.sv
module score_keeper_checker import tksk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [K_W-1:0]       cfg_wdata,
  tksk_req_if                  req,
  tksk_rsp_if                  rsp,
  output int                   errors,
  output int                   outstanding,
  output logic [SLOTS_DEF-1:0] used_mask
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result item as the block should return it.
  typedef struct packed {
    logic                 accepted;
    logic                 evicted;
    logic [SLOT_W-1:0]    slot;
    logic                 slot_used;
    logic [SCORE_W-1:0]   score;
    logic [TAG_W-1:0]     tag;
    logic [PLAYERS_W-1:0] players;
  } outcome_t;

  // Shadow copy of the slot table and the register.
  logic                 occupied    [SLOTS_DEF];
  logic [SCORE_W-1:0]   kept_score  [SLOTS_DEF];
  logic [TAG_W-1:0]     kept_tag    [SLOTS_DEF];
  logic [PLAYERS_W-1:0] kept_player [SLOTS_DEF];
  logic [K_W-1:0]       k_active;

  outcome_t due_q[$];
  int err_count = 0;

  // Applies one item to the shadow table and returns the result it must produce.
  function automatic outcome_t apply_item(input logic [OP_W-1:0] op,
                                          input logic [SCORE_W-1:0] score,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [PLAYERS_W-1:0] players,
                                          input logic [RIDX_W-1:0] ridx);
    outcome_t o;
    int span;
    int free_idx;
    int low_idx;
    int target;
    o = '0;
    if (op == OP_READ) begin
      o.slot = ridx;
      if (int'(ridx) < SLOTS_DEF) begin
        o.slot_used = occupied[ridx];
        o.score     = kept_score[ridx];
        o.tag       = kept_tag[ridx];
        o.players   = kept_player[ridx];
      end
      return o;
    end
    // A register value above the table size is clipped to the table size.
    span = (int'(k_active) > SLOTS_DEF) ? SLOTS_DEF : int'(k_active);
    free_idx = -1;
    low_idx = -1;
    for (int i = 0; i < span; i++) begin
      if (occupied[i]) begin
        if (low_idx < 0 || kept_score[i] < kept_score[low_idx]) low_idx = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    // Free slot first; otherwise replace the earliest minimum on a strictly higher score.
    if (free_idx >= 0) begin
      target = free_idx;
    end else if (low_idx >= 0 && score > kept_score[low_idx]) begin
      target = low_idx;
      o.evicted = 1'b1;
    end else begin
      return o;
    end
    occupied[target]    = 1'b1;
    kept_score[target]  = score;
    kept_tag[target]    = tag;
    kept_player[target] = players;
    o.accepted = 1'b1;
    o.slot     = target[SLOT_W-1:0];
    return o;
  endfunction

  // Reports one field that differs; returns the number of mismatches found.
  function automatic int compare_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Watch both channels and the register port at every clock edge.
  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS_DEF; i++) occupied[i] = 1'b0;
      k_active = K_ACTIVE_RST;
      due_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: result item with nothing outstanding: expected none, actual slot %0d",
                   $time, rsp.slot);
          err_count++;
        end else begin
          want = due_q.pop_front();
          err_count += compare_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
          err_count += compare_field("evicted", 32'(want.evicted), 32'(rsp.evicted));
          err_count += compare_field("slot", 32'(want.slot), 32'(rsp.slot));
          err_count += compare_field("slot_used", 32'(want.slot_used), 32'(rsp.slot_used));
          err_count += compare_field("slot_score", 32'(want.score), 32'(rsp.slot_score));
          err_count += compare_field("slot_tag", 32'(want.tag), 32'(rsp.slot_tag));
          err_count += compare_field("slot_players", 32'(want.players),
                                     32'(rsp.slot_players));
        end
      end
      if (req.valid && req.ready) begin
        due_q.push_back(apply_item(req.opcode, req.cand_score, req.cand_tag,
                                   req.cand_players, req.read_index));
      end
      if (cfg_we) k_active = cfg_wdata;
    end
    errors <= err_count;
    outstanding <= due_q.size();
    for (int i = 0; i < SLOTS_DEF; i++) used_mask[i] <= occupied[i];
  end

endmodule

### tb/top_k_score_keeper_top_tb.sv
module top_k_score_keeper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tksk_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 70;
  localparam int SETTLE      = 80;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [K_W-1:0]       cfg_wdata;
  logic                 idling_on;
  int                   mismatch_count;
  int                   results_due;
  logic [SLOTS_DEF-1:0] filled_slots;

  tksk_req_if req_ch ();
  tksk_rsp_if rsp_ch ();

  top_k_score_keeper_top #(.SLOTS(SLOTS_DEF)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  score_keeper_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (mismatch_count),
    .outstanding (results_due),
    .used_mask   (filled_slots)
  );

  always #5 clk = ~clk;

  // Register setting for each random phase, extremes included.
  function automatic logic [K_W-1:0] phase_k(input int p);
    case (p)
      0: return K_W'(64);
      1: return K_W'(127);
      2: return K_W'(1);
      3: return K_W'(0);
      4: return K_W'(5);
      5: return K_W'(2);
      6: return K_W'(16);
      7: return K_W'(64);
      8: return K_W'(10);
      default: return K_W'(40);
    endcase
  endfunction

  // Presents one item, possibly after an idle burst, and returns at the edge that takes it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SCORE_W-1:0] score,
                           input logic [TAG_W-1:0] tag, input logic [PLAYERS_W-1:0] players,
                           input logic [RIDX_W-1:0] ridx);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= op;
    req_ch.cand_score   <= score;
    req_ch.cand_tag     <= tag;
    req_ch.cand_players <= players;
    req_ch.read_index   <= ridx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic offer_candidate(input logic [SCORE_W-1:0] score, input logic [TAG_W-1:0] tag,
                                 input logic [PLAYERS_W-1:0] players);
    send_item(OP_OFFER, score, tag, players, RIDX_W'($urandom));
  endtask

  // Ignored fields of a read still carry random values.
  task automatic read_slot(input logic [RIDX_W-1:0] idx);
    send_item(OP_READ, SCORE_W'($urandom), TAG_W'($urandom), PLAYERS_W'($urandom), idx);
  endtask

  // Holds the sender until every result has come back, then writes the register.
  task automatic set_k_active(input logic [K_W-1:0] value);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: ready drops in random bursts while idling is on.
  initial begin : rsp_ready_gen
    int hold;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 16);
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("top_k_score_keeper_top regression: fail");
    $finish;
  end

  // Stimulus: reset, directed items, random phases, drain and verdict.
  initial begin : stimulus
    int start;
    int idx;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0] tag;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    idling_on           <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= OP_OFFER;
    req_ch.cand_score   <= '0;
    req_ch.cand_tag     <= '0;
    req_ch.cand_players <= '0;
    req_ch.read_index   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset setting of ten slots: field extremes go into the first two slots.
    offer_candidate('0, '0, '0);
    offer_candidate({SCORE_W{1'b1}}, {TAG_W{1'b1}}, {PLAYERS_W{1'b1}});
    read_slot(RIDX_W'(0));
    read_slot(RIDX_W'(1));

    // With no slots in use every offer is dropped.
    set_k_active(K_W'(0));
    offer_candidate(24'h7FFFFF, 32'h0000_1234, 4'd3);

    // Three slots: fill, evictions and a tie for the minimum.
    set_k_active(K_W'(3));
    offer_candidate(24'd100, 32'hA5A5_0001, 4'd2);
    offer_candidate(24'd0, 32'hA5A5_0002, 4'd4);
    offer_candidate(24'd50, 32'hA5A5_0003, 4'd5);
    offer_candidate(24'd50, 32'hA5A5_0004, 4'd6);
    offer_candidate(24'd100, 32'hA5A5_0005, 4'd7);
    offer_candidate(24'd200, 32'hA5A5_0006, 4'd8);
    offer_candidate(24'd150, 32'hA5A5_0007, 4'd9);
    read_slot(RIDX_W'(0));
    read_slot(RIDX_W'(1));
    read_slot(RIDX_W'(2));

    // A setting above the table size is clipped.
    set_k_active(K_W'(127));
    offer_candidate(24'd1, 32'h5A5A_0001, 4'd1);
    read_slot(RIDX_W'(3));

    // Random phases; phase 4 and the last two run without idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      set_k_active(phase_k(p));
      idling_on <= (p < PHASES - 2) && (p != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (filled_slots != '0 && $urandom_range(0, 9) < 3) begin
          // Read only slots known to hold a candidate.
          start = $urandom_range(0, SLOTS_DEF - 1);
          idx = start;
          for (int i = 0; i < SLOTS_DEF; i++) begin
            if (filled_slots[(start + i) % SLOTS_DEF]) begin
              idx = (start + i) % SLOTS_DEF;
              break;
            end
          end
          read_slot(RIDX_W'(idx));
        end else begin
          case ($urandom_range(0, 9))
            0: score = '0;
            1: score = {SCORE_W{1'b1}};
            2, 3, 4: score = SCORE_W'($urandom_range(0, 63));
            5, 6: score = SCORE_W'($urandom_range(0, 4095));
            default: score = SCORE_W'($urandom);
          endcase
          tag = ($urandom_range(0, 15) == 0) ? {TAG_W{1'b1}} : TAG_W'($urandom);
          offer_candidate(score, tag, PLAYERS_W'($urandom_range(0, 15)));
        end
      end
    end

    // Drain the outstanding results and let the block settle.
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("top_k_score_keeper_top regression: pass");
    end else begin
      $display("top_k_score_keeper_top regression: fail");
    end
    $finish;
  end

endmodule
